// ----- hw/rtl/upd_pkg.sv -----
// Package for the URI percent decoder: payload types, queue record, constants and helpers.
`timescale 1ns / 1ps

package upd_pkg;

    // Input request: one raw byte of the encoded string
    typedef struct packed {
        logic [7:0] char_in;
        logic       string_last;
    } t_in;

    // Output request: one result of the decoder
    typedef struct packed {
        logic [7:0] char_out;
        logic       char_present;
        logic       malformed;
        logic       run_end;
        logic       string_done;
    } t_out;

    // Work record handed from front to back: one to four results of one input byte
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            bad;
        logic            done;
    } t_rec;

    // Parser phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEX1,
        PH_HEX2,
        PH_CPCT,
        PH_CHEX1,
        PH_CHEX2,
        PH_DRAIN
    } t_phase;

    localparam logic [7:0]  CH_PCT     = 8'h25;
    localparam logic [7:0]  LEAD2_LO   = 8'hC2;
    localparam logic [7:0]  LEAD2_HI   = 8'hDF;
    localparam logic [7:0]  LEAD3_LO   = 8'hE0;
    localparam logic [7:0]  LEAD3_HI   = 8'hEF;
    localparam logic [7:0]  LEAD4_LO   = 8'hF0;
    localparam logic [7:0]  LEAD4_HI   = 8'hF4;
    localparam logic [1:0]  CONT_TAG   = 2'b10;
    localparam logic [20:0] CP_MIN2    = 21'h00080;
    localparam logic [20:0] CP_MIN3    = 21'h00800;
    localparam logic [20:0] CP_MIN4    = 21'h10000;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h0D800;
    localparam logic [20:0] SURR_HI    = 21'h0DFFF;

    // Hex digit decode: {valid, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    // Reserved set of the whole-URI mode: ; / ? : @ & = + $ , #
    function automatic logic is_reserved(input logic [7:0] b);
        return b inside {8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26,
                         8'h3D, 8'h2B, 8'h24, 8'h2C, 8'h23};
    endfunction

    // Range check of a finished UTF-8 sequence
    function automatic logic seq_ok(input logic [7:0] lead, input logic [7:0] c0,
                                    input logic [7:0] c1, input logic [7:0] c2,
                                    input logic [1:0] needed);
        logic [20:0] cp;
        logic [20:0] cp_min;
        if (needed == 2'd1) begin
            cp     = {10'd0, lead[4:0], c0[5:0]};
            cp_min = CP_MIN2;
        end else if (needed == 2'd2) begin
            cp     = {5'd0, lead[3:0], c0[5:0], c1[5:0]};
            cp_min = CP_MIN3;
        end else begin
            cp     = {lead[2:0], c0[5:0], c1[5:0], c2[5:0]};
            cp_min = CP_MIN4;
        end
        return !((cp < cp_min) || (cp > CP_MAX) || ((cp >= SURR_LO) && (cp <= SURR_HI)));
    endfunction

endpackage

// ----- hw/rtl/uri_percent_decoder.sv -----
// Top level of the URI percent decoder: front parser, record queue and result back end.
// Path: a byte's record is registered in the queue, each of its results again
// in the back end's output register. Throughput: one input byte per cycle; the back
// end gives one result per cycle unless the output stalls, with FIFO_DEPTH records
// buffered before the input stalls; a byte with N results holds the back end for all N.
// Reset: synchronous, active low; parser to idle, queue empty, keep_reserved cleared.
`timescale 1ns / 1ps

module uri_percent_decoder import upd_pkg::*; #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic q_push, q_pop, q_empty, q_full;
    t_rec q_in, q_head;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;

    // Parser
    upd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_rec       (q_in)
    );

    // Record queue
    upd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Result sequencer
    upd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- hw/rtl/upd_front.sv -----
// URI percent decoder front: escape parser, UTF-8 checker, 1 byte/cycle unless queue full.
`timescale 1ns / 1ps

module upd_front import upd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_valid,
    input  logic i_cfg_data,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    input  logic i_q_full,
    output logic o_push,
    output t_rec o_rec
);

    t_phase     r_phase, n_phase;
    logic       r_keep_res;
    logic [7:0] r_first_hex, n_first_hex;
    logic [3:0] r_high_nib, n_high_nib;
    logic [7:0] r_lead, n_lead;
    logic [7:0] r_cont [3];
    logic [7:0] n_cont [3];
    logic [1:0] r_cont_needed, n_cont_needed;
    logic [1:0] r_cont_seen, n_cont_seen;

    logic       accept;
    logic [7:0] c;
    logic [4:0] hx;
    logic [7:0] b;
    logic       err;
    logic       drain;
    logic       rec_valid;
    t_rec       rec;

    assign accept = i_in_valid && !i_q_full;
    assign c      = i_in_data.char_in;
    assign hx     = hex_nibble(c);
    assign b      = {r_high_nib, hx[3:0]};

    // Parser: next state and the record of this byte
    always_comb begin
        n_phase       = r_phase;
        n_first_hex   = r_first_hex;
        n_high_nib    = r_high_nib;
        n_lead        = r_lead;
        n_cont        = r_cont;
        n_cont_needed = r_cont_needed;
        n_cont_seen   = r_cont_seen;
        err           = 1'b0;
        drain         = 1'b0;
        rec_valid     = 1'b0;
        rec           = '0;
        case (r_phase)
            PH_IDLE: begin
                if (c == CH_PCT) begin
                    n_phase = PH_HEX1;
                end else begin
                    rec_valid     = 1'b1;
                    rec.bytes[0]  = c;
                    rec.last_idx  = 2'd0;
                end
            end
            PH_HEX1: begin
                if (!hx[4]) begin
                    err = 1'b1;
                end else begin
                    n_first_hex = c;
                    n_high_nib  = hx[3:0];
                    n_phase     = PH_HEX2;
                end
            end
            PH_HEX2: begin
                if (!hx[4]) begin
                    err = 1'b1;
                end else if (!b[7]) begin
                    rec_valid = 1'b1;
                    if (r_keep_res && is_reserved(b)) begin
                        rec.bytes[0] = CH_PCT;
                        rec.bytes[1] = r_first_hex;
                        rec.bytes[2] = c;
                        rec.last_idx = 2'd2;
                    end else begin
                        rec.bytes[0] = b;
                        rec.last_idx = 2'd0;
                    end
                    n_phase = PH_IDLE;
                end else begin
                    if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
                        n_cont_needed = 2'd1;
                    end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
                        n_cont_needed = 2'd2;
                    end else if (b inside {[LEAD4_LO:LEAD4_HI]}) begin
                        n_cont_needed = 2'd3;
                    end else begin
                        err = 1'b1;
                    end
                    if (!err) begin
                        n_lead      = b;
                        n_cont_seen = 2'd0;
                        n_phase     = PH_CPCT;
                    end
                end
            end
            PH_CPCT: begin
                if (c == CH_PCT) begin
                    n_phase = PH_CHEX1;
                end else begin
                    err = 1'b1;
                end
            end
            PH_CHEX1: begin
                if (!hx[4]) begin
                    err = 1'b1;
                end else begin
                    n_high_nib = hx[3:0];
                    n_phase    = PH_CHEX2;
                end
            end
            PH_CHEX2: begin
                if (!hx[4] || (b[7:6] != CONT_TAG)) begin
                    err = 1'b1;
                end else begin
                    if (r_cont_seen != 2'd3) begin
                        n_cont[r_cont_seen] = b;
                    end
                    n_cont_seen = r_cont_seen + 2'd1;
                    if (n_cont_seen >= r_cont_needed) begin
                        if (!seq_ok(r_lead, n_cont[0], n_cont[1], n_cont[2], r_cont_needed)) begin
                            err = 1'b1;
                        end else begin
                            rec_valid    = 1'b1;
                            rec.bytes[0] = r_lead;
                            rec.bytes[1] = n_cont[0];
                            rec.bytes[2] = n_cont[1];
                            rec.bytes[3] = n_cont[2];
                            rec.last_idx = r_cont_needed;
                            n_phase      = PH_IDLE;
                        end
                    end else begin
                        n_phase = PH_CPCT;
                    end
                end
            end
            default: begin
                // dropping the rest of a malformed string
                drain = 1'b1;
                if (i_in_data.string_last) begin
                    n_phase = PH_IDLE;
                end
            end
        endcase

        // string ending inside an escape or sequence
        if (!drain && !err && i_in_data.string_last && (n_phase != PH_IDLE)) begin
            err = 1'b1;
        end
        if (err) begin
            rec_valid = 1'b1;
            rec       = '0;
            rec.bad   = 1'b1;
            n_phase   = i_in_data.string_last ? PH_IDLE : PH_DRAIN;
        end
        rec.done = i_in_data.string_last;
    end

    assign o_push = accept && rec_valid;
    assign o_rec  = rec;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_keep_res <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
            end
            if (i_cfg_valid) begin
                r_keep_res <= i_cfg_data;
            end
        end
    end

    // Escape and sequence fields; written only while an escape is open
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cont_needed <= 2'd0;
            r_cont_seen   <= 2'd0;
        end else if (accept) begin
            r_cont_needed <= n_cont_needed;
            r_cont_seen   <= n_cont_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_first_hex <= n_first_hex;
            r_high_nib  <= n_high_nib;
            r_lead      <= n_lead;
            r_cont      <= n_cont;
        end
    end

endmodule

// ----- hw/rtl/upd_fifo.sv -----
// Record queue between the front and back ends of the URI percent decoder.
`timescale 1ns / 1ps

module upd_fifo import upd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output t_rec o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_empty = (r_count == CW'(0));
    assign o_full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/upd_back.sv -----
// Back end of the URI percent decoder: unpacks records into single results.
`timescale 1ns / 1ps

module upd_back import upd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_rec i_head,
    input  logic i_empty,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_out       r_out, n_out;
    logic       adv;
    logic       take;
    logic       at_end;

    assign adv    = !r_valid || !i_out_stall;
    assign take   = adv && !i_empty;
    assign at_end = (r_idx == i_head.last_idx);
    assign o_pop  = take && at_end;

    // Result from the current slot of the head record
    always_comb begin
        n_out              = '0;
        n_out.char_out     = i_head.bad ? 8'd0 : i_head.bytes[r_idx];
        n_out.char_present = !i_head.bad;
        n_out.malformed    = i_head.bad;
        n_out.run_end      = at_end;
        n_out.string_done  = at_end && i_head.done;
    end

    // Slot index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= !i_empty;
            if (take) begin
                r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule
